// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TTB_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TTB_ASSERT_NR(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTB_ASSERT(name, prop, msg)
`define TTB_ASSERT_NR(name, prop, msg)
`endif

`endif

// ===== rtl/core/ttb_pkg.sv =====
package ttb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int DELTA_W       = COORD_W + 1;
    localparam int PROD_W        = 2 * DELTA_W;
    localparam int NUM_W         = PROD_W + 1;
    localparam int NUM_CNT       = 7;
    localparam int LANES         = 6;
    localparam int JOB_DEPTH     = 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
        logic                      mesh_end;
    } vert_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] tangent_x;
        logic signed [COORD_W-1:0] tangent_y;
        logic signed [COORD_W-1:0] tangent_z;
        logic signed [COORD_W-1:0] bitangent_x;
        logic signed [COORD_W-1:0] bitangent_y;
        logic signed [COORD_W-1:0] bitangent_z;
        logic                      degenerate;
        logic                      mesh_done;
    } basis_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] dp1_x;
        logic signed [DELTA_W-1:0] dp1_y;
        logic signed [DELTA_W-1:0] dp1_z;
        logic signed [DELTA_W-1:0] dp2_x;
        logic signed [DELTA_W-1:0] dp2_y;
        logic signed [DELTA_W-1:0] dp2_z;
        logic signed [DELTA_W-1:0] du1;
        logic signed [DELTA_W-1:0] dv1;
        logic signed [DELTA_W-1:0] du2;
        logic signed [DELTA_W-1:0] dv2;
        logic                      last;
    } job_t;

    typedef enum logic [1:0] {
        CORNER_0 = 2'd0,
        CORNER_1 = 2'd1,
        CORNER_2 = 2'd2,
        CORNER_X = 2'd3
    } corner_t;

    function automatic logic signed [DELTA_W-1:0] dsub(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

endpackage

// ===== rtl/core/ttb_front.sv =====
module ttb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vert_valid,
    output logic          vert_stall,
    input  ttb_pkg::vert_t vert,
    output logic          job_push,
    output ttb_pkg::job_t job,
    input  logic          job_full
);
    import ttb_pkg::*;

    corner_t corner_reg, corner_next, corner_eff;
    vert_t   c0_reg, c1_reg;
    logic    accept, third;

    always_comb
    begin
        case (corner_reg)
            CORNER_1: corner_eff = CORNER_1;
            CORNER_2: corner_eff = CORNER_2;
            default:  corner_eff = CORNER_0;
        endcase
    end

    assign third      = (corner_eff == CORNER_2);
    assign vert_stall = third && job_full;
    assign accept     = vert_valid && !vert_stall;
    assign job_push   = accept && third;

    always_comb
    begin
        corner_next = corner_reg;
        if (accept)
        begin
            if (third || vert.mesh_end)
                corner_next = CORNER_0;
            else if (corner_eff == CORNER_0)
                corner_next = CORNER_1;
            else
                corner_next = CORNER_2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            corner_reg <= CORNER_0;
        else
            corner_reg <= corner_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && corner_eff == CORNER_0)
            c0_reg <= vert;
        if (accept && corner_eff == CORNER_1)
            c1_reg <= vert;
    end

    always_comb
    begin
        job.dp1_x = dsub(c1_reg.pos_x, c0_reg.pos_x);
        job.dp1_y = dsub(c1_reg.pos_y, c0_reg.pos_y);
        job.dp1_z = dsub(c1_reg.pos_z, c0_reg.pos_z);
        job.dp2_x = dsub(vert.pos_x, c0_reg.pos_x);
        job.dp2_y = dsub(vert.pos_y, c0_reg.pos_y);
        job.dp2_z = dsub(vert.pos_z, c0_reg.pos_z);
        job.du1   = dsub(c1_reg.tex_u, c0_reg.tex_u);
        job.dv1   = dsub(c1_reg.tex_v, c0_reg.tex_v);
        job.du2   = dsub(vert.tex_u, c0_reg.tex_u);
        job.dv2   = dsub(vert.tex_v, c0_reg.tex_v);
        job.last  = vert.mesh_end;
    end

endmodule

// ===== rtl/core/ttb_queue.sv =====
`include "assert_macros.svh"

module ttb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ttb_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          job_valid,
    output ttb_pkg::job_t job
);
    import ttb_pkg::*;

    localparam int PW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CW = $clog2(JOB_DEPTH + 1);

    job_t          mem_reg [JOB_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    assign full      = (count_reg == CW'(JOB_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && job_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(JOB_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_next + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(JOB_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    `TTB_ASSERT(a_no_push_full, push |-> !full, "job pushed into full queue")
    `TTB_ASSERT(a_count_range, count_reg <= CW'(JOB_DEPTH), "queue count out of range")
    `TTB_ASSERT(a_pop_valid, pop |-> job_valid, "job popped from empty queue")

endmodule

// ===== rtl/core/ttb_back.sv =====
`include "assert_macros.svh"

module ttb_back #(
    parameter int FRAC_BITS = ttb_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  ttb_pkg::job_t  job,
    output logic           job_pop,
    output logic           basis_valid,
    input  logic           basis_stall,
    output ttb_pkg::basis_t basis
);
    import ttb_pkg::*;

    localparam int CW = NUM_W + 33;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_ROUND = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    job_t                     job_reg;
    logic [3:0]               cnt_reg;
    logic [3:0]               pidx_reg;
    logic                     pvld_reg;
    logic signed [PROD_W-1:0] prod_reg, first_reg, prod_next;
    logic signed [NUM_W-1:0]  num_reg [NUM_CNT];
    logic signed [DELTA_W-1:0] opa, opb;
    logic signed [DELTA_W-1:0] dp1 [3];
    logic signed [DELTA_W-1:0] dp2 [3];

    logic [NUM_W-1:0]   dmag_reg;
    logic [CW-1:0]      dsh_reg;
    logic [CW-1:0]      rem_reg [LANES];
    logic [COORD_W-1:0] q_reg   [LANES];
    logic               sat_reg [LANES];
    logic               neg_reg [LANES];
    logic [COORD_W-1:0] res_reg [LANES];
    logic               degen_reg;
    logic [4:0]         bit_reg;
    logic               issue, load;
    basis_t             basis_reg;
    logic               basis_valid_reg;

    assign dp1[0] = job_reg.dp1_x;
    assign dp1[1] = job_reg.dp1_y;
    assign dp1[2] = job_reg.dp1_z;
    assign dp2[0] = job_reg.dp2_x;
    assign dp2[1] = job_reg.dp2_y;
    assign dp2[2] = job_reg.dp2_z;

    assign job_pop     = (state_reg == ST_IDLE) && job_valid;
    assign issue       = (state_reg == ST_MUL) && (cnt_reg != 4'd14);
    assign load        = (state_reg == ST_DONE) && (!basis_valid_reg || !basis_stall);
    assign basis_valid = basis_valid_reg;
    assign basis       = basis_reg;

    always_comb
    begin
        case (cnt_reg[3:1])
            3'd0:    begin opa = cnt_reg[0] ? job_reg.dv1 : job_reg.du1;
                           opb = cnt_reg[0] ? job_reg.du2 : job_reg.dv2; end
            3'd1:    begin opa = cnt_reg[0] ? dp2[0] : dp1[0];
                           opb = cnt_reg[0] ? job_reg.dv1 : job_reg.dv2; end
            3'd2:    begin opa = cnt_reg[0] ? dp2[1] : dp1[1];
                           opb = cnt_reg[0] ? job_reg.dv1 : job_reg.dv2; end
            3'd3:    begin opa = cnt_reg[0] ? dp2[2] : dp1[2];
                           opb = cnt_reg[0] ? job_reg.dv1 : job_reg.dv2; end
            3'd4:    begin opa = cnt_reg[0] ? dp1[0] : dp2[0];
                           opb = cnt_reg[0] ? job_reg.du2 : job_reg.du1; end
            3'd5:    begin opa = cnt_reg[0] ? dp1[1] : dp2[1];
                           opb = cnt_reg[0] ? job_reg.du2 : job_reg.du1; end
            3'd6:    begin opa = cnt_reg[0] ? dp1[2] : dp2[2];
                           opb = cnt_reg[0] ? job_reg.du2 : job_reg.du1; end
            default: begin opa = '0; opb = '0; end
        endcase
        prod_next = opa * opb;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (job_valid) state_next = ST_MUL;
            ST_MUL:   if (cnt_reg == 4'd14) state_next = ST_SETUP;
            ST_SETUP: state_next = (num_reg[0] == '0) ? ST_DONE : ST_DIV;
            ST_DIV:   if (bit_reg == '0) state_next = ST_ROUND;
            ST_ROUND: state_next = ST_DONE;
            ST_DONE:  if (load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pvld_reg        <= 1'b0;
            basis_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pvld_reg  <= issue;
            if (load)
                basis_valid_reg <= 1'b1;
            else if (!basis_stall)
                basis_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [NUM_W-1:0] nm;
        logic [NUM_W-1:0] dm;
        logic [COORD_W:0] qf;
        logic [COORD_W:0] qc;
        if (job_pop)
        begin
            job_reg <= job;
            cnt_reg <= '0;
        end
        if (state_reg == ST_MUL)
            cnt_reg <= cnt_reg + 1'b1;
        if (issue)
        begin
            prod_reg <= prod_next;
            pidx_reg <= cnt_reg;
        end
        if (pvld_reg)
        begin
            if (!pidx_reg[0])
                first_reg <= prod_reg;
            else
                num_reg[pidx_reg[3:1]] <= NUM_W'(first_reg) - NUM_W'(prod_reg);
        end
        if (state_reg == ST_SETUP)
        begin
            dm        = num_reg[0][NUM_W-1] ? (~num_reg[0] + 1'b1) : num_reg[0];
            degen_reg <= (num_reg[0] == '0);
            dmag_reg  <= dm;
            dsh_reg   <= CW'(dm) << 31;
            bit_reg   <= 5'd31;
            for (int l = 0; l < LANES; l++)
            begin
                nm = num_reg[l+1][NUM_W-1] ? (~num_reg[l+1] + 1'b1) : num_reg[l+1];
                rem_reg[l] <= CW'(nm) << FRAC_BITS;
                sat_reg[l] <= (CW'(nm) << FRAC_BITS) >= (CW'(dm) << 32);
                neg_reg[l] <= num_reg[l+1][NUM_W-1] ^ num_reg[0][NUM_W-1];
                q_reg[l]   <= '0;
                res_reg[l] <= '0;
            end
        end
        if (state_reg == ST_DIV)
        begin
            dsh_reg <= dsh_reg >> 1;
            bit_reg <= bit_reg - 1'b1;
            for (int l = 0; l < LANES; l++)
            begin
                if (!sat_reg[l] && rem_reg[l] >= dsh_reg)
                begin
                    rem_reg[l] <= rem_reg[l] - dsh_reg;
                    q_reg[l]   <= {q_reg[l][COORD_W-2:0], 1'b1};
                end
                else
                    q_reg[l]   <= {q_reg[l][COORD_W-2:0], 1'b0};
            end
        end
        if (state_reg == ST_ROUND)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (sat_reg[l])
                    qf = {1'b1, {COORD_W{1'b0}}};
                else
                    qf = {1'b0, q_reg[l]} +
                         (COORD_W+1)'((rem_reg[l] << 1) >= CW'(dmag_reg));
                if (!neg_reg[l])
                begin
                    qc = (qf > (COORD_W+1)'(32'h7FFF_FFFF)) ? (COORD_W+1)'(32'h7FFF_FFFF) : qf;
                    res_reg[l] <= qc[COORD_W-1:0];
                end
                else
                begin
                    qc = (qf > (COORD_W+1)'(32'h8000_0000)) ? (COORD_W+1)'(32'h8000_0000) : qf;
                    res_reg[l] <= ~qc[COORD_W-1:0] + 1'b1;
                end
            end
        end
        if (load)
        begin
            basis_reg.tangent_x   <= res_reg[0];
            basis_reg.tangent_y   <= res_reg[1];
            basis_reg.tangent_z   <= res_reg[2];
            basis_reg.bitangent_x <= res_reg[3];
            basis_reg.bitangent_y <= res_reg[4];
            basis_reg.bitangent_z <= res_reg[5];
            basis_reg.degenerate  <= degen_reg;
            basis_reg.mesh_done   <= job_reg.last;
        end
    end

    `TTB_ASSERT(a_load_valid, load |=> basis_valid_reg, "loaded result not presented")
    `TTB_ASSERT(a_degen_zero, basis_valid_reg && basis_reg.degenerate |-> basis_reg.tangent_x == '0 && basis_reg.bitangent_z == '0, "degenerate result not zero")
    `TTB_ASSERT(a_pop_idle, job_pop |=> state_reg == ST_MUL && cnt_reg == '0, "job start lost")

endmodule

// ===== rtl/core/triangle_tangent_basis.sv =====
// Channel  Dir  Payload                 Handshake
// vert     in   ttb_pkg::vert_t         vert_valid / vert_stall
// basis    out  ttb_pkg::basis_t        basis_valid / basis_stall
//
// Corners 0 and 1 are registered; the third is queued when it is accepted.
// The back end takes one job at a time; it uses one shared 33x33 multiplier
// for 14 products and a 32-step restoring divide, skipped when degenerate.
// A two-entry job queue lets vertex intake run ahead of the back end.
// Reset is asynchronous, active low; no clearing pass is needed.
// The third corner stalls only while the job queue is full.
module triangle_tangent_basis #(
    parameter int FRAC_BITS = ttb_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            vert_valid,
    output logic            vert_stall,
    input  ttb_pkg::vert_t  vert,
    output logic            basis_valid,
    input  logic            basis_stall,
    output ttb_pkg::basis_t basis
);
    import ttb_pkg::*;

    job_t job_in, job_out;
    logic push, pop, full, q_valid;

    ttb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vert_valid (vert_valid),
        .vert_stall (vert_stall),
        .vert       (vert),
        .job_push   (push),
        .job        (job_in),
        .job_full   (full)
    );

    ttb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (job_in),
        .full      (full),
        .pop       (pop),
        .job_valid (q_valid),
        .job       (job_out)
    );

    ttb_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job         (job_out),
        .job_pop     (pop),
        .basis_valid (basis_valid),
        .basis_stall (basis_stall),
        .basis       (basis)
    );

endmodule
